>>> design/box_filter_halving_downscaler_macros.svh
// Assertion macros for the box filter halving downscaler.
`ifndef BOX_FILTER_HALVING_DOWNSCALER_MACROS_SVH
`define BOX_FILTER_HALVING_DOWNSCALER_MACROS_SVH

`ifndef SYNTHESIS
`define BFHD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfhd assertion failed");
`define BFHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfhd assertion failed");
`else
`define BFHD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BFHD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/bfhd_pkg.sv
package bfhd_pkg;

    localparam int PIX_W = 32;
    localparam int SUM_W = 36;
    localparam int DIM_W = 13;
    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_MAX_SIZE     = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic             active;
    } t_geom;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_lvl_out;

    function automatic logic [SUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int ch = 0; ch < 4; ch++) begin
            s[9*ch +: 9] = {1'b0, a[8*ch +: 8]} + {1'b0, b[8*ch +: 8]};
        end
        return s;
    endfunction

    function automatic logic [PIX_W-1:0] average4(input logic [SUM_W-1:0] s0,
                                                  input logic [SUM_W-1:0] s1);
        logic [PIX_W-1:0] p;
        logic [9:0]       v;
        p = '0;
        for (int ch = 0; ch < 4; ch++) begin
            v = {1'b0, s0[9*ch +: 9]} + {1'b0, s1[9*ch +: 9]};
            p[8*ch +: 8] = v[9:2];
        end
        return p;
    endfunction

endpackage

>>> design/bfhd_in_if.sv
interface bfhd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] in_pixel;
    modport source(output valid, output in_pixel, input ready);
    modport sink(input valid, input in_pixel, output ready);
endinterface

>>> design/bfhd_out_if.sv
interface bfhd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_pixel;
    logic        out_last;
    modport source(output valid, output out_pixel, output out_last, input ready);
    modport sink(input valid, input out_pixel, input out_last, output ready);
endinterface

>>> design/bfhd_ram.sv
module bfhd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/bfhd_front.sv
module bfhd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bfhd_in_if.sink       i_in,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [31:0]   o_pixel
);
    import bfhd_pkg::*;

    logic [PIX_W-1:0] r_mem [2];
    logic             r_wptr, n_wptr;
    logic             r_rptr, n_rptr;
    logic [1:0]       r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign i_in.ready = (r_count != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_count != 2'd0);
    assign o_valid    = (r_count != 2'd0);
    assign o_pixel    = r_mem[r_rptr];

    always_comb begin
        n_wptr  = w_push ? ~r_wptr : r_wptr;
        n_rptr  = w_pop ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_in.in_pixel;
        end
    end
endmodule

>>> design/bfhd_level.sv
module bfhd_level #(
    parameter int DEPTH = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  bfhd_pkg::t_geom     i_geom,
    input  logic                i_valid,
    input  logic [31:0]         i_pixel,
    output bfhd_pkg::t_lvl_out  o_out
);
    import bfhd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_held;
    logic             r_vb, n_vb;
    logic             r_byp_b;
    logic [PIX_W-1:0] r_pix_b;
    logic [SUM_W-1:0] r_ps_b;
    logic             r_last_b;
    logic [SUM_W-1:0] w_rdata;
    logic [SUM_W-1:0] w_ps;
    logic [31:0]      w_half_col;
    logic [AW-1:0]    w_addr;
    logic             w_take;
    logic             w_inrange;
    logic             w_we;
    logic             w_re;
    logic             w_last_byp;
    logic             w_last_avg;
    logic [DIM_W-1:0] w_wh;
    logic [DIM_W-1:0] w_hh;

    assign w_take     = i_adv && i_valid;
    assign w_inrange  = (r_col < {i_geom.w[DIM_W-1:1], 1'b0}) &&
                        (r_row < {i_geom.h[DIM_W-1:1], 1'b0});
    assign w_ps       = pair_sum(r_held, i_pixel);
    assign w_half_col = {{(32-DIM_W){1'b0}}, r_col} >> 1;
    assign w_addr     = w_half_col[AW-1:0];
    assign w_we       = w_take && i_geom.active && w_inrange && r_col[0] && !r_row[0];
    assign w_re       = w_take && i_geom.active && w_inrange && r_col[0] && r_row[0];
    assign w_wh       = i_geom.w >> 1;
    assign w_hh       = i_geom.h >> 1;
    assign w_last_byp = (r_col == i_geom.w - DIM_W'(1)) && (r_row == i_geom.h - DIM_W'(1));
    assign w_last_avg = ((r_col >> 1) == w_wh - DIM_W'(1)) &&
                        ((r_row >> 1) == w_hh - DIM_W'(1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if ({1'b0, r_col} + 14'd1 >= {1'b0, i_geom.w}) begin
            n_col = '0;
            if ({1'b0, r_row} + 14'd1 >= {1'b0, i_geom.h}) begin
                n_row = '0;
            end else begin
                n_row = r_row + DIM_W'(1);
            end
        end else begin
            n_col = r_col + DIM_W'(1);
        end
        n_vb = w_take && (!i_geom.active || w_re);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
            r_vb   <= 1'b0;
        end else begin
            if (w_take) begin
                r_col <= n_col;
                r_row <= n_row;
                if (i_geom.active && w_inrange && !r_col[0]) begin
                    r_held <= i_pixel;
                end
            end
            if (i_adv) begin
                r_vb <= n_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byp_b  <= !i_geom.active;
            r_pix_b  <= i_pixel;
            r_ps_b   <= w_ps;
            r_last_b <= i_geom.active ? w_last_avg : w_last_byp;
        end
    end

    bfhd_ram #(
        .WIDTH(SUM_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_addr),
        .i_wdata(w_ps),
        .i_re   (w_re),
        .i_raddr(w_addr),
        .o_rdata(w_rdata)
    );

    assign o_out.valid = r_vb;
    assign o_out.pixel = r_byp_b ? r_pix_b : average4(w_rdata, r_ps_b);
    assign o_out.last  = r_last_b;
endmodule

>>> design/box_filter_halving_downscaler.sv
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    in_pixel[31:0]
// o_out     out  valid/ready    out_pixel[31:0], out_last
// APB       in   psel/penable   paddr[3:0], pwdata[31:0], prdata[31:0]
// One pixel is accepted per clock while the output keeps draining.
// The data path is registered in the input queue, in each active level (in the single bypass level
// when no level halves), and in the output register.
// Each level reads and writes its own pair-sum RAM once per pixel at most.
// An output stall freezes the level chain; a two-word queue keeps taking input until it is full.
// Reset is synchronous; pair-sum RAMs are not cleared.
`include "box_filter_halving_downscaler_macros.svh"

module box_filter_halving_downscaler #(
    parameter int MAX_WIDTH = 4096,
    parameter int LEVELS    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bfhd_in_if.sink                       i_in,
    bfhd_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfhd_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bfhd_pkg::*;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] r_max;
    logic [DIM_W-1:0] w_wc;
    logic [DIM_W-1:0] w_hc;
    t_reg_idx         w_idx;
    logic             w_cfg_we;

    t_geom            w_geom [LEVELS];
    t_lvl_out         w_lvl  [LEVELS];
    logic             w_lvl_in_valid [LEVELS];
    logic [PIX_W-1:0] w_lvl_in_pixel [LEVELS];
    logic [LEVELS-1:0] w_sel;

    logic             w_q_valid;
    logic [PIX_W-1:0] w_q_pixel;
    logic             w_adv;
    logic             w_sel_valid;
    logic [PIX_W-1:0] w_sel_pixel;
    logic             w_sel_last;

    logic             r_out_valid, n_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_last;

    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[3:2]);
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(4096);
            r_height <= DIM_W'(4096);
            r_max    <= DIM_W'(1024);
        end else if (w_cfg_we) begin
            case (w_idx)
                REG_IMAGE_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_MAX_SIZE:     r_max    <= pwdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_IMAGE_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, r_width};
            REG_IMAGE_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, r_height};
            REG_MAX_SIZE:     prdata = {{(32-DIM_W){1'b0}}, r_max};
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (r_width == '0) begin
            w_wc = DIM_W'(1);
        end else if ({{(32-DIM_W){1'b0}}, r_width} > 32'(MAX_WIDTH)) begin
            w_wc = DIM_W'(MAX_WIDTH);
        end else begin
            w_wc = r_width;
        end
        w_hc = (r_height == '0) ? DIM_W'(1) : r_height;
    end

    assign w_adv = !r_out_valid || o_out.ready;

    bfhd_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_pop  (w_adv),
        .o_valid(w_q_valid),
        .o_pixel(w_q_pixel)
    );

    for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
        localparam int LD = ((MAX_WIDTH >> (k + 1)) > 0) ? (MAX_WIDTH >> (k + 1)) : 1;
        logic [DIM_W-1:0] w_wk;
        logic [DIM_W-1:0] w_hk;

        assign w_wk = w_wc >> k;
        assign w_hk = w_hc >> k;
        assign w_geom[k].w = w_wk;
        assign w_geom[k].h = w_hk;
        assign w_geom[k].active = ((w_wk > r_max) || (w_hk > r_max)) &&
                                  (w_wk >= DIM_W'(2)) && (w_hk >= DIM_W'(2));

        if (k == 0) begin : g_first
            assign w_lvl_in_valid[k] = w_q_valid;
            assign w_lvl_in_pixel[k] = w_q_pixel;
        end else begin : g_next
            assign w_lvl_in_valid[k] = w_lvl[k-1].valid && w_geom[k].active;
            assign w_lvl_in_pixel[k] = w_lvl[k-1].pixel;
        end

        if (k == LEVELS - 1) begin : g_sel_end
            assign w_sel[k] = (k == 0) ? 1'b1 : w_geom[k].active;
        end else if (k == 0) begin : g_sel_first
            assign w_sel[k] = !w_geom[k+1].active;
        end else begin : g_sel_mid
            assign w_sel[k] = w_geom[k].active && !w_geom[k+1].active;
        end

        bfhd_level #(
            .DEPTH(LD)
        ) u_level (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_adv),
            .i_geom (w_geom[k]),
            .i_valid(w_lvl_in_valid[k]),
            .i_pixel(w_lvl_in_pixel[k]),
            .o_out  (w_lvl[k])
        );
    end

    always_comb begin
        w_sel_valid = 1'b0;
        w_sel_pixel = '0;
        w_sel_last  = 1'b0;
        for (int k = 0; k < LEVELS; k++) begin
            w_sel_valid = w_sel_valid | (w_sel[k] & w_lvl[k].valid);
            w_sel_pixel = w_sel_pixel | ({PIX_W{w_sel[k]}} & w_lvl[k].pixel);
            w_sel_last  = w_sel_last | (w_sel[k] & w_lvl[k].last);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = w_sel_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_sel_valid) begin
            r_out_pixel <= w_sel_pixel;
            r_out_last  <= w_sel_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_pixel = r_out_pixel;
    assign o_out.out_last  = r_out_last;

    `BFHD_ASSERT_IMP(a_sel_onehot, i_clk, i_rst_n, 1'b1, $onehot(w_sel))
    `BFHD_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, w_adv && w_sel_valid, r_out_valid)
    `BFHD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !o_out.ready,
                      r_out_valid && $stable(r_out_pixel))
endmodule
